// ===== rtl/core/pcte_pkg.sv =====
// Shared types, constants and location-table functions for the PDCCH
// candidate tree energy core. No dependencies.
package pcte_pkg;

    localparam int LLR_W        = 16;
    localparam int BITS_PER_CCE = 72;
    localparam int CCE_PER_BLK  = 8;
    localparam int LOCS_PER_BLK = 15;

    localparam int SUM_W     = 22;
    localparam int LOC_SUM_W = 25;
    localparam int CNT_W     = 8;
    localparam int NBLK_W    = 6;
    localparam int BLK_W     = 5;
    localparam int BIT_W     = 7;
    localparam int CCE_W     = 3;
    localparam int K_W       = 4;
    localparam int LVL_W     = 2;
    localparam int FIRST_W   = 7;
    localparam int MEAN_W    = 16;
    localparam int QX_W      = 22;
    localparam int PROD_W    = 44;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // floor(x / 9) = (x * DIV9_MUL) >> DIV9_SHIFT, exact for x < 2^22
    localparam logic [QX_W-1:0] DIV9_MUL   = 22'd3728271;
    localparam int              DIV9_SHIFT = 25;

    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_CCE - 1);
    localparam logic [CCE_W-1:0] LAST_CCE = CCE_W'(CCE_PER_BLK - 1);
    localparam logic [K_W-1:0]   LAST_K   = K_W'(LOCS_PER_BLK - 1);

    typedef enum logic [1:0] {
        REG_CFI  = 2'd0,
        REG_CNT1 = 2'd1,
        REG_CNT2 = 2'd2,
        REG_CNT3 = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CCE_PER_BLK-1:0][SUM_W-1:0] sums;
        logic [BLK_W-1:0]                  blk;
        logic [CNT_W-1:0]                  count;
        logic                              last_region;
    } t_snap;

    // tree order: level 3, two at level 2, four at level 1, eight at level 0
    function automatic logic [LVL_W-1:0] loc_level(input logic [K_W-1:0] k);
        logic [LVL_W-1:0] l;
        l = 2'd0;
        if (k == 4'd0)      l = 2'd3;
        else if (k < 4'd3)  l = 2'd2;
        else if (k < 4'd7)  l = 2'd1;
        return l;
    endfunction

    function automatic logic [CCE_W-1:0] loc_off(input logic [K_W-1:0] k);
        logic [K_W-1:0] t;
        t = 4'd0;
        if (k == 4'd0)      t = 4'd0;
        else if (k < 4'd3)  t = (k - 4'd1) << 2;
        else if (k < 4'd7)  t = (k - 4'd3) << 1;
        else                t = k - 4'd7;
        return t[CCE_W-1:0];
    endfunction

endpackage

// ===== rtl/core/pcte_cfg.sv =====
// APB register file: CFI and the three per-CFI CCE counts.
// Supplies the saturated CCE count of the region. Uses pcte_pkg.
module pcte_cfg
    import pcte_pkg::*;
#(
    parameter int MAX_CCE = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [CNT_W-1:0]  o_region_cces
);

    logic [1:0]       r_cfi;
    logic [CNT_W-1:0] r_cnt1;
    logic [CNT_W-1:0] r_cnt2;
    logic [CNT_W-1:0] r_cnt3;
    t_reg_idx         idx;
    logic             wr;
    logic [CNT_W-1:0] n_sel;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfi  <= 2'd1;
            r_cnt1 <= '0;
            r_cnt2 <= '0;
            r_cnt3 <= '0;
        end else if (wr) begin
            unique case (idx)
                REG_CFI:  r_cfi  <= pwdata[1:0];
                REG_CNT1: r_cnt1 <= pwdata[CNT_W-1:0];
                REG_CNT2: r_cnt2 <= pwdata[CNT_W-1:0];
                REG_CNT3: r_cnt3 <= pwdata[CNT_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CFI:  prdata = {30'd0, r_cfi};
            REG_CNT1: prdata = {24'd0, r_cnt1};
            REG_CNT2: prdata = {24'd0, r_cnt2};
            REG_CNT3: prdata = {24'd0, r_cnt3};
            default:  prdata = '0;
        endcase
    end

    always_comb begin
        unique case (r_cfi)
            2'd1:    n_sel = r_cnt1;
            2'd2:    n_sel = r_cnt2;
            2'd3:    n_sel = r_cnt3;
            default: n_sel = '0;
        endcase
        o_region_cces = n_sel;
        if ({1'b0, n_sel} > 9'(MAX_CCE)) begin
            o_region_cces = CNT_W'(MAX_CCE);
        end
    end

endmodule

// ===== rtl/core/pcte_accum.sv =====
// Input register, per-CCE absolute-LLR accumulators and block/region
// counters; hands a block snapshot to the emitter. Uses pcte_pkg.
module pcte_accum
    import pcte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [LLR_W-1:0]  i_soft_bit,
    input  logic [CNT_W-1:0]  i_region_cces,
    input  logic              i_emit_busy,
    output logic              o_start,
    output t_snap             o_snap
);

    logic                              r_in_vld;
    logic [LLR_W-1:0]                  r_in_llr;
    logic [CCE_PER_BLK-1:0][SUM_W-1:0] r_sum;
    logic [BIT_W-1:0]                  r_bit;
    logic [CCE_W-1:0]                  r_cce;
    logic [BLK_W-1:0]                  r_blk;

    logic [LLR_W-1:0]  abs_llr;
    logic              blk_end;
    logic              fire;
    logic [NBLK_W-1:0] nblk;
    logic              have_blk;
    logic              last_region;
    logic [CNT_W:0]    cnt_rnd;

    assign abs_llr = r_in_llr[LLR_W-1] ? (~r_in_llr + 1'b1) : r_in_llr;
    assign blk_end = (r_bit == LAST_BIT) && (r_cce == LAST_CCE);
    assign fire    = r_in_vld && !(blk_end && i_emit_busy);
    assign o_in_ready = !r_in_vld || fire;

    assign cnt_rnd     = {1'b0, i_region_cces} + 9'(CCE_PER_BLK - 1);
    assign nblk        = cnt_rnd[CNT_W:3];
    assign have_blk    = {1'b0, r_blk} < nblk;
    assign last_region = ({1'b0, r_blk} + 6'd1) == nblk;

    always_comb begin
        o_snap             = '0;
        o_snap.sums        = r_sum;
        o_snap.sums[LAST_CCE] = r_sum[LAST_CCE] + SUM_W'(abs_llr);
        o_snap.blk         = r_blk;
        o_snap.count       = i_region_cces;
        o_snap.last_region = last_region;
        o_start            = fire && blk_end && have_blk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_sum    <= '0;
            r_bit    <= '0;
            r_cce    <= '0;
            r_blk    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (fire) begin
                if (blk_end) begin
                    r_sum <= '0;
                    r_bit <= '0;
                    r_cce <= '0;
                    r_blk <= (have_blk && !last_region) ? r_blk + 1'b1 : '0;
                end else begin
                    r_sum[r_cce] <= r_sum[r_cce] + SUM_W'(abs_llr);
                    if (r_bit == LAST_BIT) begin
                        r_bit <= '0;
                        r_cce <= r_cce + 1'b1;
                    end else begin
                        r_bit <= r_bit + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_llr <= i_soft_bit;
        end
    end

endmodule

// ===== rtl/core/pcte_emit.sv =====
// Location sequencer: walks the 15 tree locations of a block snapshot,
// sums CCEs, divides by 72<<level and drives the result register. Uses pcte_pkg.
module pcte_emit
    import pcte_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_snap              i_snap,
    output logic               o_busy,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [LVL_W-1:0]   o_agg_level,
    output logic [FIRST_W-1:0] o_first_cce,
    output logic [MEAN_W-1:0]  o_mean_abs_llr,
    output logic               o_invalid,
    output logic               o_last_of_block,
    output logic               o_last_of_region
);

    t_snap          r_snap;
    logic           r_active;
    logic [K_W-1:0] r_k;

    logic                 r_s1_vld;
    logic [LOC_SUM_W-1:0] r_s1_sum;
    logic [LVL_W-1:0]     r_s1_lvl;
    logic [FIRST_W-1:0]   r_s1_first;
    logic                 r_s1_inv;
    logic                 r_s1_lob;
    logic                 r_s1_lor;

    logic                 r_o_vld;
    logic [LVL_W-1:0]     r_o_lvl;
    logic [FIRST_W-1:0]   r_o_first;
    logic [MEAN_W-1:0]    r_o_mean;
    logic                 r_o_inv;
    logic                 r_o_lob;
    logic                 r_o_lor;

    logic                 out_en;
    logic                 s1_en;
    logic [LVL_W-1:0]     lvl;
    logic [CCE_W-1:0]     off;
    logic [LOC_SUM_W-1:0] n_sum;
    logic [CNT_W-1:0]     first_full;
    logic [CNT_W:0]       loc_end;
    logic [LOC_SUM_W-1:0] shifted;
    logic [QX_W-1:0]      qx;
    logic [PROD_W-1:0]    prod;

    assign out_en = !r_o_vld || i_out_ready;
    assign s1_en  = !r_s1_vld || out_en;
    assign o_busy = r_active;

    assign lvl        = loc_level(r_k);
    assign off        = loc_off(r_k);
    assign first_full = {r_snap.blk, off};
    assign loc_end    = {1'b0, first_full} + (9'd1 << lvl);

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < CCE_PER_BLK; i++) begin
            if ((CCE_W'(i) >> lvl) == (off >> lvl)) begin
                n_sum = n_sum + LOC_SUM_W'(r_snap.sums[i]);
            end
        end
    end

    assign shifted = r_s1_sum >> (3 + r_s1_lvl);
    assign qx      = shifted[QX_W-1:0];
    assign prod    = PROD_W'(qx) * PROD_W'(DIV9_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_k      <= '0;
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (i_start && !r_active) begin
                r_active <= 1'b1;
                r_k      <= '0;
            end else if (r_active && s1_en) begin
                r_k <= r_k + 1'b1;
                if (r_k == LAST_K) begin
                    r_active <= 1'b0;
                end
            end
            if (s1_en) begin
                r_s1_vld <= r_active;
            end
            if (out_en) begin
                r_o_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_active) begin
            r_snap <= i_snap;
        end
        if (s1_en) begin
            r_s1_sum   <= n_sum;
            r_s1_lvl   <= lvl;
            r_s1_first <= first_full[FIRST_W-1:0];
            r_s1_inv   <= loc_end > {1'b0, r_snap.count};
            r_s1_lob   <= r_k == LAST_K;
            r_s1_lor   <= (r_k == LAST_K) && r_snap.last_region;
        end
        if (out_en) begin
            r_o_lvl   <= r_s1_lvl;
            r_o_first <= r_s1_first;
            r_o_mean  <= prod[DIV9_SHIFT +: MEAN_W];
            r_o_inv   <= r_s1_inv;
            r_o_lob   <= r_s1_lob;
            r_o_lor   <= r_s1_lor;
        end
    end

    assign o_out_valid      = r_o_vld;
    assign o_agg_level      = r_o_lvl;
    assign o_first_cce      = r_o_first;
    assign o_mean_abs_llr   = r_o_mean;
    assign o_invalid        = r_o_inv;
    assign o_last_of_block  = r_o_lob;
    assign o_last_of_region = r_o_lor;

endmodule

// ===== rtl/core/pdcch_candidate_tree_energy_core.sv =====
// PDCCH candidate tree energy core: 15 tree locations out per 8-CCE block of the region.
// Uses pcte_pkg, pcte_cfg, pcte_accum, pcte_emit.
// A block's last soft bit passes the input register, snapshot, location and result registers.
// Throughput: 1 soft bit/cycle; input stalls only if a block completes while
// the previous block's 15 locations still occupy the location sequencer.
// Reset: synchronous active low; sums, counters cleared, cfi=1, counts=0.
module pdcch_candidate_tree_energy_core
    import pcte_pkg::*;
#(
    parameter int MAX_CCE = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [LLR_W-1:0]   i_soft_bit,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [LVL_W-1:0]   o_agg_level,
    output logic [FIRST_W-1:0] o_first_cce,
    output logic [MEAN_W-1:0]  o_mean_abs_llr,
    output logic               o_invalid,
    output logic               o_last_of_block,
    output logic               o_last_of_region
);

    logic [CNT_W-1:0] region_cces;
    logic             emit_busy;
    logic             start;
    t_snap            snap;

    pcte_cfg #(
        .MAX_CCE(MAX_CCE)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_region_cces (region_cces)
    );

    pcte_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_soft_bit    (i_soft_bit),
        .i_region_cces (region_cces),
        .i_emit_busy   (emit_busy),
        .o_start       (start),
        .o_snap        (snap)
    );

    pcte_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_snap           (snap),
        .o_busy           (emit_busy),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_agg_level      (o_agg_level),
        .o_first_cce      (o_first_cce),
        .o_mean_abs_llr   (o_mean_abs_llr),
        .o_invalid        (o_invalid),
        .o_last_of_block  (o_last_of_block),
        .o_last_of_region (o_last_of_region)
    );

endmodule

// ===== rtl/core/pcte_checker.sv =====
// Port-level assertions for the candidate tree energy core, bound to the
// top level. Uses pcte_pkg.
module pcte_checker
    import pcte_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [LVL_W-1:0]   o_agg_level,
    input logic [FIRST_W-1:0] o_first_cce,
    input logic [MEAN_W-1:0]  o_mean_abs_llr,
    input logic               o_invalid,
    input logic               o_last_of_block,
    input logic               o_last_of_region
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_agg_level)
            && $stable(o_first_cce) && $stable(o_mean_abs_llr) && $stable(o_invalid))
        else $error("result transaction changed while stalled");

    a_region_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_region |-> o_last_of_block)
        else $error("region end without block end");

    a_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_block |-> o_agg_level == 2'd0 && o_first_cce[2:0] == 3'd7)
        else $error("block end on wrong location");

    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_mean_abs_llr <= 16'd32768)
        else $error("mean out of range");

endmodule

bind pdcch_candidate_tree_energy_core pcte_checker u_pcte_checker (.*);

// ===== test/pdcch_candidate_tree_energy_core_test.sv =====
// Self-checking testbench for pdcch_candidate_tree_energy_core: streams soft bits in
// whole 8-CCE blocks, predicts the 15 candidate locations per block and checks each
// one. Depends on pcte_pkg and the core RTL.
`timescale 1ns / 1ps

module pdcch_candidate_tree_energy_core_test;
    import pcte_pkg::*;

    localparam int MAX_CCE     = 128;
    localparam int CYCLE_LIMIT = 800000;
    localparam int SETTLE      = 8;
    localparam int RAND_LOCS   = 75;
    localparam logic [7:0][LLR_W-1:0] EDGE_LLRS = {
        16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h8001, 16'h5555, 16'hAAAA
    };

    typedef enum int {
        FILL_RANDOM,
        FILL_NEG_FULL,
        FILL_POS_FULL,
        FILL_ZERO,
        FILL_SMALL
    } t_fill;

    typedef struct {
        logic [LVL_W-1:0]   lvl;
        logic [FIRST_W-1:0] first;
        logic [MEAN_W-1:0]  mean;
        logic               inv;
        logic               lob;
        logic               lor;
    } t_loc;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [LLR_W-1:0]   i_soft_bit = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [LVL_W-1:0]   o_agg_level;
    logic [FIRST_W-1:0] o_first_cce;
    logic [MEAN_W-1:0]  o_mean_abs_llr;
    logic               o_invalid;
    logic               o_last_of_block;
    logic               o_last_of_region;

    pdcch_candidate_tree_energy_core #(.MAX_CCE(MAX_CCE)) dut (.*);

    always #6 i_clk = ~i_clk;

    logic [LLR_W-1:0] soft_bit_q[$];
    t_loc             loc_expect_q[$];
    int               send_gap_pct = 0;
    int               ready_gap_pct = 0;
    int               locs_seen = 0;
    int               mismatches = 0;
    int               cycles = 0;

    // shadow of the register file and of the accumulator state
    logic [1:0] cfg_cfi = 2'd1;
    logic [7:0] cfg_cce_count[1:3] = '{8'd0, 8'd0, 8'd0};
    int         cce_sum[CCE_PER_BLK] = '{default: 0};
    int         bit_pos = 0;
    int         cce_pos = 0;
    int         blk_pos = 0;

    function automatic int region_cces();
        int n;
        n = (cfg_cfi == 2'd0) ? 0 : int'(cfg_cce_count[cfg_cfi]);
        return (n > MAX_CCE) ? MAX_CCE : n;
    endfunction

    task automatic flag(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    task automatic absorb_soft_bit(input logic [LLR_W-1:0] llr);
        int   mag, count, nblk, k, lvl, j, i, span, first, total;
        t_loc loc;
        mag = int'($signed(llr));
        if (mag < 0) mag = -mag;
        cce_sum[cce_pos] += mag;
        if (bit_pos != BITS_PER_CCE - 1) begin
            bit_pos++;
            return;
        end
        bit_pos = 0;
        if (cce_pos != CCE_PER_BLK - 1) begin
            cce_pos++;
            return;
        end
        cce_pos = 0;
        count = region_cces();
        nblk = (count + CCE_PER_BLK - 1) / CCE_PER_BLK;
        if (blk_pos < nblk) begin
            k = 0;
            for (lvl = 3; lvl >= 0; lvl--) begin
                for (j = 0; j < (CCE_PER_BLK >> lvl); j++) begin
                    span = 1 << lvl;
                    first = blk_pos * CCE_PER_BLK + (j << lvl);
                    total = 0;
                    for (i = 0; i < span; i++) total += cce_sum[(j << lvl) + i];
                    loc.lvl = LVL_W'(lvl);
                    loc.first = FIRST_W'(first);
                    loc.mean = MEAN_W'(total / (BITS_PER_CCE << lvl));
                    loc.inv = (first + span > count);
                    loc.lob = (k == LOCS_PER_BLK - 1);
                    loc.lor = (k == LOCS_PER_BLK - 1) && (blk_pos + 1 == nblk);
                    loc_expect_q.push_back(loc);
                    k++;
                end
            end
            blk_pos = (blk_pos + 1 == nblk) ? 0 : (blk_pos + 1) % 32;
        end else begin
            blk_pos = 0;
        end
        for (i = 0; i < CCE_PER_BLK; i++) cce_sum[i] = 0;
    endtask

    // soft bit source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) absorb_soft_bit(i_soft_bit);
            if (!i_in_valid || o_in_ready) begin
                if (soft_bit_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_soft_bit <= soft_bit_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // location sink and checker
    always @(posedge i_clk) begin : location_check
        t_loc want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            locs_seen++;
            if (loc_expect_q.size() == 0) begin
                flag($sformatf("unexpected location: lvl %0d first %0d mean %0d inv %0b",
                               o_agg_level, o_first_cce, o_mean_abs_llr, o_invalid));
            end else begin
                want = loc_expect_q.pop_front();
                if (o_agg_level !== want.lvl || o_first_cce !== want.first ||
                    o_mean_abs_llr !== want.mean || o_invalid !== want.inv ||
                    o_last_of_block !== want.lob || o_last_of_region !== want.lor) begin
                    flag($sformatf({"location mismatch: expected lvl %0d first %0d mean %0d",
                                    " inv %0b lob %0b lor %0b, got lvl %0d first %0d mean %0d",
                                    " inv %0b lob %0b lor %0b"},
                                   want.lvl, want.first, want.mean, want.inv, want.lob,
                                   want.lor, o_agg_level, o_first_cce, o_mean_abs_llr,
                                   o_invalid, o_last_of_block, o_last_of_region));
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= ready_gap_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("pdcch_candidate_tree_energy_core regression: fail");
            $finish;
        end
    end

    task automatic cfg_write(input t_reg_idx idx, input logic [7:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CFI:  cfg_cfi = val[1:0];
            REG_CNT1: cfg_cce_count[1] = val;
            REG_CNT2: cfg_cce_count[2] = val;
            REG_CNT3: cfg_cce_count[3] = val;
        endcase
    endtask

    function automatic logic [LLR_W-1:0] make_llr(input t_fill f);
        case (f)
            FILL_NEG_FULL: return 16'h8000;
            FILL_POS_FULL: return 16'h7FFF;
            FILL_ZERO:     return 16'h0000;
            FILL_SMALL:    return LLR_W'($urandom_range(64)) - 16'd32;
            default:       return LLR_W'($urandom);
        endcase
    endfunction

    // one whole 8-CCE block of soft bits; the directed one leads with edge values
    task automatic push_block(input bit directed);
        t_fill f;
        int    c, b;
        for (c = 0; c < CCE_PER_BLK; c++) begin
            if (directed) begin
                case (c)
                    1, 6:    f = FILL_NEG_FULL;
                    2:       f = FILL_POS_FULL;
                    3:       f = FILL_ZERO;
                    4:       f = FILL_SMALL;
                    default: f = FILL_RANDOM;
                endcase
            end else begin
                f = ($urandom_range(1) == 0) ? FILL_RANDOM : t_fill'($urandom_range(4));
            end
            for (b = 0; b < BITS_PER_CCE; b++) begin
                if (directed && c == 0 && b < 8) soft_bit_q.push_back(EDGE_LLRS[b]);
                else soft_bit_q.push_back(make_llr(f));
            end
        end
    endtask

    task automatic wait_idle();
        while (soft_bit_q.size() != 0 || i_in_valid || loc_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [1:0] cfi, input logic [7:0] n1, n2, n3,
                             input int blocks, input bit directed);
        int b;
        cfg_write(REG_CFI, {6'd0, cfi});
        cfg_write(REG_CNT1, n1);
        cfg_write(REG_CNT2, n2);
        cfg_write(REG_CNT3, n3);
        for (b = 0; b < blocks; b++) push_block(directed && b == 0);
        wait_idle();
    endtask

    function automatic logic [7:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 8'd0;
        if (r < 12) return 8'($urandom_range(129, 255));
        if (r < 88) return 8'($urandom_range(1, 24));
        return 8'($urandom_range(25, 64));
    endfunction

    initial begin : stimulus
        int         base, phases;
        logic [1:0] cfi;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct = 17;
        ready_gap_pct = 53;

        // reset settings: zero CCEs, block is consumed silently
        push_block(1'b1);
        wait_idle();
        // full block, partial block, then a fresh region
        run_phase(2'd1, 8'd13, 8'd0, 8'd255, 3, 1'b1);
        // leftover block index past the new region end, then single-block region
        run_phase(2'd2, 8'd13, 8'd8, 8'd255, 2, 1'b0);
        run_phase(2'd0, 8'd13, 8'd8, 8'd255, 1, 1'b0);
        // saturated count, full 16-block region
        run_phase(2'd3, 8'd1, 8'd8, 8'd255, 16, 1'b0);
        run_phase(2'd1, 8'd1, 8'd8, 8'd128, 1, 1'b1);
        run_phase(2'd2, 8'd1, 8'd0, 8'd128, 1, 1'b0);

        base = locs_seen;
        phases = 0;
        while (locs_seen - base < RAND_LOCS && phases < 60) begin
            if (locs_seen - base >= 2 * RAND_LOCS / 3) begin
                send_gap_pct = 0;
                ready_gap_pct = 0;
            end else if (locs_seen - base >= RAND_LOCS / 3) begin
                send_gap_pct = 53;
                ready_gap_pct = 17;
            end
            cfi = ($urandom_range(9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
            run_phase(cfi, pick_count(), pick_count(), pick_count(),
                      $urandom_range(1, 3), 1'b0);
            phases++;
        end

        repeat (20) @(posedge i_clk);
        if (loc_expect_q.size() != 0)
            flag($sformatf("%0d expected locations never arrived", loc_expect_q.size()));
        if (mismatches == 0) begin
            $display("pdcch_candidate_tree_energy_core regression: pass");
        end else begin
            $display("pdcch_candidate_tree_energy_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pcte_pkg.sv
rtl/core/pcte_cfg.sv
rtl/core/pcte_accum.sv
rtl/core/pcte_emit.sv
rtl/core/pdcch_candidate_tree_energy_core.sv
rtl/core/pcte_checker.sv
test/pdcch_candidate_tree_energy_core_test.sv
